[rtl/core/touch_hysteresis_debouncer_unit_macros.svh]
// Assertion macros used by the checker file of the touch debouncer.
`ifndef TOUCH_HYSTERESIS_DEBOUNCER_UNIT_MACROS_SVH
`define TOUCH_HYSTERESIS_DEBOUNCER_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define THD_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define THD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define THD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/thd_pkg.sv]
package thd_pkg;

    // Fixed field widths.
    localparam int ELECTRODE_W  = 4;
    localparam int SAMPLE_W     = 10;
    localparam int BASELINE_W   = 8;
    localparam int MASK_W       = 12;
    localparam int DELTA_W      = 11;
    localparam int GAIN_W       = 9;
    localparam int THRESH_W     = 11;
    localparam int COUNT_W      = 8;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 11;

    // Gain is in units of 1/256.
    localparam int GAIN_SHIFT   = 8;
    localparam int GAIN_ONE     = 256;
    localparam int GAIN_HALF    = 128;

    // Parameter defaults.
    localparam int ELECTRODES_DEF    = 12;
    localparam int FRACTION_BITS_DEF = 8;

    // Register reset values.
    localparam logic [GAIN_W-1:0]          GAIN_RST     = 9'd26;
    localparam logic signed [THRESH_W-1:0] TOUCH_RST    = -11'sd12;
    localparam logic signed [THRESH_W-1:0] RELEASE_RST  = -11'sd6;
    localparam logic [COUNT_W-1:0]         DEBOUNCE_RST = 8'd3;

    // Register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SMOOTHING_GAIN    = 2'd0,
        REG_TOUCH_THRESHOLD   = 2'd1,
        REG_RELEASE_THRESHOLD = 2'd2,
        REG_DEBOUNCE_COUNT    = 2'd3
    } cfg_reg_t;

    // Increment a qualifier count, saturating at the debounce count.
    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] count,
                                                 input logic [COUNT_W-1:0] limit);
        logic [COUNT_W:0] inc;
        inc = {1'b0, count} + (COUNT_W+1)'(1);
        if (inc > {1'b0, limit}) begin
            return limit;
        end
        return inc[COUNT_W-1:0];
    endfunction

endpackage

[rtl/core/touch_hysteresis_debouncer_unit.sv]
// Touch qualifier for a bank of capacitive electrodes.
// Each input word on the s_ channel carries one electrode sample: the electrode
// index, the filtered reading and the baseline divided by four. The block forms
// the delta, folds it into that electrode's exponential average, and runs the
// touch/release qualifier with hysteresis and debounce for that electrode.
// Each input word produces exactly one result word on the m_ channel: the
// 12-bit touch mask after the update, the sampled electrode's touched flag and
// the integer part of its smoothed delta. An index beyond the electrode count
// changes nothing and reports the current mask with a zero flag and delta.
// Timing: a word sits in the input register while the whole update (one
// multiply, one add, a saturation and the compares) settles, and moves into
// the result register, raising m_valid, once that register is empty or being
// drained. One word can be accepted every cycle while the receiver keeps up;
// the per-electrode state is written on the edge that loads the result, so
// back-to-back samples of the same electrode see each other's updates.
// When the receiver stalls, the result register holds and the input register
// fills; s_ready drops only while both are occupied and m_ready is low.
// Reset (aresetn low, synchronous) clears both valid flags, loads the register
// defaults and clears every electrode's average, flag and counts. Writes on cfg_we take
// effect at once; the user must make them only while no word is in flight; the block does not enforce this.
module touch_hysteresis_debouncer_unit #(
    parameter int ELECTRODES    = thd_pkg::ELECTRODES_DEF,
    parameter int FRACTION_BITS = thd_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration write port.
    input  logic                                  cfg_we,
    input  logic [thd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [thd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    // Sample input channel.
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [thd_pkg::ELECTRODE_W-1:0]       s_electrode,
    input  logic [thd_pkg::SAMPLE_W-1:0]          s_filtered_sample,
    input  logic [thd_pkg::BASELINE_W-1:0]        s_baseline_upper,
    // Result channel.
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [thd_pkg::MASK_W-1:0]            m_touch_mask,
    output logic                                  m_electrode_touched,
    output logic signed [thd_pkg::DELTA_W-1:0]    m_smoothed_delta
);

    // Smoothed value: integer part of DELTA_W bits plus the fraction bits.
    localparam int SW      = thd_pkg::DELTA_W + FRACTION_BITS;
    localparam int DIFF_W  = SW + 1;
    localparam int GMUL_W  = thd_pkg::GAIN_W + 1;
    localparam int PROD_W  = DIFF_W + GMUL_W;
    localparam int STEP_W  = PROD_W - thd_pkg::GAIN_SHIFT;
    localparam int SUM_W   = STEP_W + 1;
    localparam int IDX_W   = (ELECTRODES > 1) ? $clog2(ELECTRODES) : 1;
    localparam int WIDE_W  = thd_pkg::MASK_W + ELECTRODES;

    // Configuration registers.
    logic [thd_pkg::GAIN_W-1:0]          gain_reg;
    logic signed [thd_pkg::THRESH_W-1:0] touch_thr_reg;
    logic signed [thd_pkg::THRESH_W-1:0] release_thr_reg;
    logic [thd_pkg::COUNT_W-1:0]         debounce_reg;

    // Input register.
    logic                                in_valid_reg;
    logic [thd_pkg::ELECTRODE_W-1:0]     in_electrode_reg;
    logic [thd_pkg::SAMPLE_W-1:0]        in_sample_reg;
    logic [thd_pkg::BASELINE_W-1:0]      in_baseline_reg;

    // Result register.
    logic                                out_valid_reg;
    logic [thd_pkg::MASK_W-1:0]          out_mask_reg;
    logic                                out_touched_reg;
    logic signed [thd_pkg::DELTA_W-1:0]  out_delta_reg;

    // Per-electrode state.
    logic signed [SW-1:0]                smooth_reg  [ELECTRODES];
    logic [ELECTRODES-1:0]               touched_reg;
    logic [thd_pkg::COUNT_W-1:0]         tcount_reg  [ELECTRODES];
    logic [thd_pkg::COUNT_W-1:0]         rcount_reg  [ELECTRODES];

    // Datapath signals.
    logic                                advance;
    logic                                update;
    logic                                in_range;
    logic [IDX_W-1:0]                    idx;
    logic signed [thd_pkg::DELTA_W-1:0]  delta;
    logic signed [SW-1:0]                target;
    logic signed [SW-1:0]                s_cur;
    logic signed [DIFF_W-1:0]            diff;
    logic [thd_pkg::GAIN_W-1:0]          gain_eff;
    logic signed [PROD_W-1:0]            prod;
    logic signed [PROD_W-1:0]            rounded;
    logic signed [STEP_W-1:0]            step;
    logic signed [SUM_W-1:0]             sum;
    logic signed [SW-1:0]                smooth_next;
    logic signed [SW-1:0]                touch_thr_s;
    logic signed [SW-1:0]                release_thr_s;
    logic                                below_touch;
    logic                                above_release;
    logic                                flag_cur;
    logic                                flag_next;
    logic [thd_pkg::COUNT_W-1:0]         tcount_cur;
    logic [thd_pkg::COUNT_W-1:0]         rcount_cur;
    logic [thd_pkg::COUNT_W-1:0]         tcount_next;
    logic [thd_pkg::COUNT_W-1:0]         rcount_next;
    logic [thd_pkg::COUNT_W-1:0]         count_bumped;
    logic [ELECTRODES-1:0]               touched_next;
    logic [WIDE_W-1:0]                   touched_wide;
    logic [thd_pkg::MASK_W-1:0]          mask_next;

    // The result register moves whenever it is empty or being drained; the
    // input register accepts whenever it is empty or moving on.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign update  = advance && in_valid_reg && in_range;

    assign in_range = {1'b0, in_electrode_reg} < (thd_pkg::ELECTRODE_W+1)'(ELECTRODES);
    assign idx      = in_electrode_reg[IDX_W-1:0];

    // Exponential average: s' = s + floor((g * (D - s) + 128) / 256), then
    // saturated to the integer range of the result.
    always_comb begin
        delta    = $signed({1'b0, in_sample_reg}) - $signed({1'b0, in_baseline_reg, 2'b00});
        target   = {delta, {FRACTION_BITS{1'b0}}};
        s_cur    = smooth_reg[idx];
        diff     = $signed({target[SW-1], target}) - $signed({s_cur[SW-1], s_cur});
        gain_eff = gain_reg[thd_pkg::GAIN_W-1] ? thd_pkg::GAIN_W'(thd_pkg::GAIN_ONE) : gain_reg;
        prod     = $signed({{(PROD_W-DIFF_W){diff[DIFF_W-1]}}, diff})
                 * $signed({{(PROD_W-thd_pkg::GAIN_W){1'b0}}, gain_eff});
        rounded  = prod + PROD_W'(thd_pkg::GAIN_HALF);
        step     = rounded[PROD_W-1:thd_pkg::GAIN_SHIFT];
        sum      = $signed({{(SUM_W-SW){s_cur[SW-1]}}, s_cur})
                 + $signed({step[STEP_W-1], step});
        // Saturate: if the bits above the result's sign do not all match it,
        // clamp to the most negative or most positive value.
        if (sum[SUM_W-1:SW-1] == {(SUM_W-SW+1){1'b0}} ||
            sum[SUM_W-1:SW-1] == {(SUM_W-SW+1){1'b1}}) begin
            smooth_next = sum[SW-1:0];
        end else if (sum[SUM_W-1]) begin
            smooth_next = {1'b1, {(SW-1){1'b0}}};
        end else begin
            smooth_next = {1'b0, {(SW-1){1'b1}}};
        end
    end

    // Hysteresis qualifier with debounce counts.
    always_comb begin
        touch_thr_s   = {touch_thr_reg, {FRACTION_BITS{1'b0}}};
        release_thr_s = {release_thr_reg, {FRACTION_BITS{1'b0}}};
        below_touch   = smooth_next < touch_thr_s;
        above_release = smooth_next > release_thr_s;
        flag_cur      = 1'b0;
        tcount_cur    = '0;
        rcount_cur    = '0;
        for (int i = 0; i < ELECTRODES; i++) begin
            if (idx == IDX_W'(i)) begin
                flag_cur   = touched_reg[i];
                tcount_cur = tcount_reg[i];
                rcount_cur = rcount_reg[i];
            end
        end
        flag_next    = flag_cur;
        tcount_next  = tcount_cur;
        rcount_next  = rcount_cur;
        count_bumped = '0;
        if (!flag_cur) begin
            if (below_touch) begin
                count_bumped = thd_pkg::bump(tcount_cur, debounce_reg);
                tcount_next  = count_bumped;
                if (count_bumped >= debounce_reg) begin
                    flag_next   = 1'b1;
                    rcount_next = '0;
                end
            end else begin
                tcount_next = '0;
            end
        end else begin
            if (above_release) begin
                count_bumped = thd_pkg::bump(rcount_cur, debounce_reg);
                rcount_next  = count_bumped;
                if (count_bumped >= debounce_reg) begin
                    flag_next   = 1'b0;
                    tcount_next = '0;
                end
            end else begin
                rcount_next = '0;
            end
        end

        touched_next = touched_reg;
        for (int i = 0; i < ELECTRODES; i++) begin
            if (in_range && idx == IDX_W'(i)) begin
                touched_next[i] = flag_next;
            end
        end
        // Only the first twelve electrodes appear in the mask.
        touched_wide = WIDE_W'(touched_next);
        mask_next    = touched_wide[thd_pkg::MASK_W-1:0];
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg        <= thd_pkg::GAIN_RST;
            touch_thr_reg   <= thd_pkg::TOUCH_RST;
            release_thr_reg <= thd_pkg::RELEASE_RST;
            debounce_reg    <= thd_pkg::DEBOUNCE_RST;
        end else if (cfg_we) begin
            case (thd_pkg::cfg_reg_t'(cfg_index))
                thd_pkg::REG_SMOOTHING_GAIN: begin
                    gain_reg <= cfg_wdata[thd_pkg::GAIN_W-1:0];
                end
                thd_pkg::REG_TOUCH_THRESHOLD: begin
                    touch_thr_reg <= $signed(cfg_wdata[thd_pkg::THRESH_W-1:0]);
                end
                thd_pkg::REG_RELEASE_THRESHOLD: begin
                    release_thr_reg <= $signed(cfg_wdata[thd_pkg::THRESH_W-1:0]);
                end
                thd_pkg::REG_DEBOUNCE_COUNT: begin
                    debounce_reg <= cfg_wdata[thd_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Input payload register.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_electrode_reg <= s_electrode;
            in_sample_reg    <= s_filtered_sample;
            in_baseline_reg  <= s_baseline_upper;
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_mask_reg <= mask_next;
            if (in_range) begin
                out_touched_reg <= flag_next;
                out_delta_reg   <= smooth_next[SW-1:FRACTION_BITS];
            end else begin
                out_touched_reg <= 1'b0;
                out_delta_reg   <= '0;
            end
        end
    end

    // Per-electrode state, written on the edge that registers the result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            touched_reg <= '0;
            for (int i = 0; i < ELECTRODES; i++) begin
                smooth_reg[i] <= '0;
                tcount_reg[i] <= '0;
                rcount_reg[i] <= '0;
            end
        end else if (update) begin
            touched_reg <= touched_next;
            for (int i = 0; i < ELECTRODES; i++) begin
                if (idx == IDX_W'(i)) begin
                    smooth_reg[i] <= smooth_next;
                    tcount_reg[i] <= tcount_next;
                    rcount_reg[i] <= rcount_next;
                end
            end
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_touch_mask        = out_mask_reg;
    assign m_electrode_touched = out_touched_reg;
    assign m_smoothed_delta    = out_delta_reg;

endmodule

[rtl/core/thd_checker.sv]
`include "touch_hysteresis_debouncer_unit_macros.svh"

module thd_checker #(
    parameter int ELECTRODES = thd_pkg::ELECTRODES_DEF
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic [thd_pkg::MASK_W-1:0]            m_touch_mask,
    input logic                                  m_electrode_touched,
    input logic signed [thd_pkg::DELTA_W-1:0]    m_smoothed_delta
);

    // A stalled result word keeps its contents.
    `THD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_touch_mask) && $stable(m_electrode_touched) &&
        $stable(m_smoothed_delta), "stalled result word changed")

    // Reset empties the result register.
    `THD_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid,
        "result valid right after reset")

    // With the result register empty, the input side can never be blocked.
    `THD_ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready,
        "input stalled while result register empty")

    // A touched flag implies a nonempty mask when every electrode is within the mask range.
    `THD_ASSERT_IMPLY(a_flag_in_mask, aclk, aresetn, m_valid && m_electrode_touched,
        (ELECTRODES > thd_pkg::MASK_W) || (m_touch_mask != '0),
        "touched flag with an empty mask")

endmodule

bind touch_hysteresis_debouncer_unit thd_checker #(
    .ELECTRODES(ELECTRODES)
) u_thd_checker (.*);
